// ----- hdl/ffts_pkg.sv -----
// Shared constants and types for the float frame tail synchroniser.
package ffts_pkg;

    localparam int CHANNELS  = 16;
    localparam int WIN_BYTES = 4 * CHANNELS + 4;
    localparam int FILL_W    = $clog2(WIN_BYTES);
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] TAIL_B0      = 8'h00;
    localparam logic [7:0] TAIL_B1      = 8'h00;
    localparam logic [7:0] TAIL_B2      = 8'h80;
    localparam logic [7:0] TAIL_B3      = 8'h7F;
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic [CHANNELS-1:0][31:0] words;
        logic                      all_finite;
        logic [31:0]               number;
    } t_frame;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_flags;

endpackage

// ----- hdl/ffts_front.sv -----
// Byte window, tail marker detection and frame capture.
module ffts_front
    import ffts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic [7:0] i_rx_byte,
    input  t_q_flags i_flags,
    output logic     o_push,
    output t_frame   o_frame
);

    logic [WIN_BYTES-1:0][7:0] r_win;
    logic [FILL_W-1:0]         r_fill;
    logic [FILL_W-1:0]         n_fill;
    logic [31:0]               r_count;
    logic [31:0]               n_count;
    logic                      at_edge;
    logic                      tail_ok;
    logic                      accept;
    logic                      finite;

    assign at_edge = (r_fill == FILL_W'(WIN_BYTES - 1));
    assign tail_ok = (r_win[WIN_BYTES-3] == TAIL_B0) && (r_win[WIN_BYTES-2] == TAIL_B1)
                  && (r_win[WIN_BYTES-1] == TAIL_B2) && (i_rx_byte == TAIL_B3);
    assign o_ready = !(i_flags.full && at_edge);
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && at_edge && tail_ok;
    assign n_count = r_count + 32'd1;

    // The frame is taken from the window as it will stand after this byte shifts in.
    always_comb begin
        finite = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            o_frame.words[i] = {r_win[4*i+4], r_win[4*i+3], r_win[4*i+2], r_win[4*i+1]};
            if (o_frame.words[i][30:23] == EXP_ALL_ONES) begin
                finite = 1'b0;
            end
        end
        o_frame.all_finite = finite;
        o_frame.number     = n_count;
    end

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            if (at_edge) begin
                n_fill = tail_ok ? '0 : r_fill;
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= {i_rx_byte, r_win[WIN_BYTES-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_fill <= n_fill;
            if (o_push) begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ----- hdl/ffts_queue.sv -----
// Short queue of captured frames between the front and back parts.
module ffts_queue
    import ffts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_frame   i_frame,
    input  logic     i_pop,
    output t_frame   o_frame,
    output t_q_flags o_flags
);

    t_frame            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_frame           = r_mem[r_rp];
    assign o_flags.full      = (r_cnt == QCNT_W'(QDEPTH));
    assign o_flags.not_empty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_flags.full) else $error("Frame pushed into a full queue.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_flags.not_empty) else $error("Frame popped from an empty queue.");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH)) else $error("Queue count exceeds its depth.");

endmodule

// ----- hdl/ffts_back.sv -----
// Word sequencer that emits one float word per transaction from the queued frame.
module ffts_back
    import ffts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame      i_frame,
    input  t_q_flags    i_flags,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_channel_index,
    output logic [31:0] o_channel_bits,
    output logic        o_frame_last,
    output logic        o_frame_all_finite,
    output logic [31:0] o_frame_number
);

    t_frame           r_frame;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [3:0]       r_out_index;
    logic [31:0]      r_out_bits;
    logic             r_out_last;
    logic             r_out_finite;
    logic [31:0]      r_out_number;
    logic             advance;
    logic             emit;
    logic             is_last;

    assign advance = !r_out_valid || i_ready;
    assign emit    = advance && r_busy;
    assign is_last = (r_idx == IDX_W'(CHANNELS - 1));
    assign o_pop   = i_flags.not_empty && (!r_busy || (emit && is_last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
        if (emit) begin
            r_out_index  <= 4'(r_idx);
            r_out_bits   <= r_frame.words[r_idx];
            r_out_last   <= is_last;
            r_out_finite <= r_frame.all_finite;
            r_out_number <= r_frame.number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_channel_index    = r_out_index;
    assign o_channel_bits     = r_out_bits;
    assign o_frame_last       = r_out_last;
    assign o_frame_all_finite = r_out_finite;
    assign o_frame_number     = r_out_number;

    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_busy && r_idx == '0)) else $error("Popped frame did not start at word zero.");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid) else $error("Emitted word not presented.");

endmodule

// ----- hdl/float_frame_tail_sync_core.sv -----
// Top level of the float frame tail synchroniser.
//
//  Channel  Direction  Handshake            Payload
//  rx       in         i_valid / o_ready    i_rx_byte
//  words    out        o_valid / i_ready    o_channel_index, o_channel_bits, o_frame_last,
//                                           o_frame_all_finite, o_frame_number
//
// One byte is accepted per cycle while o_ready is high; the window is a 68-byte shift line.
// A matched frame goes into a two-entry frame queue and is sent as 16 word
// transactions, one per cycle while i_ready is high, through a registered output stage.
// The byte input stalls only on the byte that would complete a window while the queue is full.
// Reset is synchronous and active low; it clears the fill count, frame counter, queue and word sequencer state.
module float_frame_tail_sync_core
    import ffts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_channel_index,
    output logic [31:0] o_channel_bits,
    output logic        o_frame_last,
    output logic        o_frame_all_finite,
    output logic [31:0] o_frame_number
);

    t_frame   push_frame;
    t_frame   head_frame;
    t_q_flags q_flags;
    logic     push;
    logic     pop;

    ffts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_flags   (q_flags),
        .o_push    (push),
        .o_frame   (push_frame)
    );

    ffts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (head_frame),
        .o_flags (q_flags)
    );

    ffts_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_frame            (head_frame),
        .i_flags            (q_flags),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_channel_index    (o_channel_index),
        .o_channel_bits     (o_channel_bits),
        .o_frame_last       (o_frame_last),
        .o_frame_all_finite (o_frame_all_finite),
        .o_frame_number     (o_frame_number)
    );

endmodule
